// ===== rtl/complex_arithmetic_unit_top_macros.svh =====
// Assertion macros for the complex arithmetic unit.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define CAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CAU_ASSERT_IMP(lbl, ante, cons, msg)
`define CAU_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/cau_pkg.sv =====
`default_nettype none
package cau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PW        = 2 * WORD_BITS;         // full product
  localparam int SW        = PW + 1;                // sum of two products
  localparam int RW        = PW;                    // remainder, radicand, divisor
  localparam int MW        = PW + 2;                // magnitude into the clamp
  localparam int CW        = 3 * WORD_BITS + 2 * FRAC_BITS + 1;
  localparam int NCELL     = WORD_BITS;             // one quotient or root bit per cell
  localparam int OPW       = 4;

  localparam logic [OPW-1:0] OP_ADD   = 4'd0;
  localparam logic [OPW-1:0] OP_SUB   = 4'd1;
  localparam logic [OPW-1:0] OP_MUL   = 4'd2;
  localparam logic [OPW-1:0] OP_DIV   = 4'd3;
  localparam logic [OPW-1:0] OP_NEG   = 4'd4;
  localparam logic [OPW-1:0] OP_CONJ  = 4'd5;
  localparam logic [OPW-1:0] OP_MAG   = 4'd6;
  localparam logic [OPW-1:0] OP_RECIP = 4'd7;
  localparam logic [OPW-1:0] OP_LESS  = 4'd8;
  localparam logic [OPW-1:0] OP_EQUAL = 4'd9;

  typedef struct packed {
    logic [OPW-1:0]              action;
    logic signed [WORD_BITS-1:0] a_real;
    logic signed [WORD_BITS-1:0] a_imag;
    logic signed [WORD_BITS-1:0] b_real;
    logic signed [WORD_BITS-1:0] b_imag;
  } in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] res_real;
    logic signed [WORD_BITS-1:0] res_imag;
    logic                        compare_true;
    logic                        div_by_zero;
    logic                        saturated;
  } out_t;

  typedef struct packed {
    logic [RW-1:0]        rem;
    logic [RW-1:0]        src;
    logic [WORD_BITS-1:0] q;
  } lane_t;

  typedef struct packed {
    logic [OPW-1:0] op;
    out_t           direct;
    logic [1:0]     neg;
    logic [1:0]     ovf;
  } tag_t;

  typedef struct packed {
    logic            valid;
    tag_t            tag;
    logic            sqrt_mode;
    logic [RW-1:0]   den;
    lane_t [1:0]     lane;
  } stage_t;

  typedef struct packed {
    logic                 sat;
    logic [WORD_BITS-1:0] word;
  } clamp_t;

  // Clamp a sign-magnitude value to the signed word range.
  function automatic clamp_t clamp_mag(input logic neg, input logic [MW-1:0] mag);
    clamp_t        r;
    logic [MW-1:0] lim;
    lim    = MW'(1) << (WORD_BITS - 1);
    r.sat  = 1'b0;
    r.word = mag[WORD_BITS-1:0];
    if (!neg && mag >= lim) begin
      r.sat  = 1'b1;
      r.word = {1'b0, {(WORD_BITS-1){1'b1}}};
    end else if (neg && mag > lim) begin
      r.sat  = 1'b1;
      r.word = {1'b1, {(WORD_BITS-1){1'b0}}};
    end else if (neg) begin
      r.word = WORD_BITS'(0) - mag[WORD_BITS-1:0];
    end
    return r;
  endfunction

  // Clamp a two's complement value one bit wider than a word.
  function automatic clamp_t clamp_sgn(input logic signed [WORD_BITS:0] v);
    logic [WORD_BITS:0] mag;
    mag = v[WORD_BITS] ? (WORD_BITS+1)'(-v) : (WORD_BITS+1)'(v);
    return clamp_mag(v[WORD_BITS], MW'(mag));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cau_prep.sv =====
`default_nettype none
module cau_prep (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_take,
  input  cau_pkg::in_t    in_data,
  output cau_pkg::stage_t head
);
  import cau_pkg::*;

  // stage 1: products and the simple operations
  logic                        p1_valid_r;
  logic [OPW-1:0]              p1_op_r;
  logic signed [WORD_BITS-1:0] p1_are_r, p1_aim_r;
  out_t                        p1_dir_r, p1_dir_nxt;
  logic signed [PW-1:0]        p1_prod_r [4];
  logic signed [PW-1:0]        p1_prod_nxt [4];
  logic [PW-1:0]               p1_sq_r [2];
  logic [PW-1:0]               p1_sq_nxt [2];

  // stage 2: sums
  logic                        p2_valid_r;
  logic [OPW-1:0]              p2_op_r;
  out_t                        p2_dir_r;
  logic signed [SW-1:0]        p2_s_r [2];
  logic signed [SW-1:0]        p2_s_nxt [2];
  logic [RW-1:0]               p2_den_r, p2_den_nxt;

  // stage 3: lane setup
  logic                        head_valid_r;
  stage_t                      head_r, head_nxt;

  always_comb begin
    logic signed [WORD_BITS-1:0] dre, dim;
    logic signed [WORD_BITS:0]   xar, xai, xbr, xbi;
    clamp_t                      c_re, c_im;
    logic                        cmp;
    dre  = (in_data.action == OP_DIV) ? in_data.b_real : in_data.a_real;
    dim  = (in_data.action == OP_DIV) ? in_data.b_imag : in_data.a_imag;
    p1_prod_nxt[0] = PW'(in_data.a_real) * PW'(in_data.b_real);
    p1_prod_nxt[1] = PW'(in_data.a_imag) * PW'(in_data.b_imag);
    p1_prod_nxt[2] = PW'(in_data.a_imag) * PW'(in_data.b_real);
    p1_prod_nxt[3] = PW'(in_data.a_real) * PW'(in_data.b_imag);
    p1_sq_nxt[0]   = PW'(PW'(dre) * PW'(dre));
    p1_sq_nxt[1]   = PW'(PW'(dim) * PW'(dim));
    xar  = (WORD_BITS+1)'(in_data.a_real);
    xai  = (WORD_BITS+1)'(in_data.a_imag);
    xbr  = (WORD_BITS+1)'(in_data.b_real);
    xbi  = (WORD_BITS+1)'(in_data.b_imag);
    c_re = '0;
    c_im = '0;
    cmp  = 1'b0;
    unique case (in_data.action)
      OP_ADD: begin
        c_re = clamp_sgn(xar + xbr);
        c_im = clamp_sgn(xai + xbi);
      end
      OP_SUB: begin
        c_re = clamp_sgn(xar - xbr);
        c_im = clamp_sgn(xai - xbi);
      end
      OP_NEG: begin
        c_re = clamp_sgn(-xar);
        c_im = clamp_sgn(-xai);
      end
      OP_CONJ: begin
        c_re = clamp_sgn(xar);
        c_im = clamp_sgn(-xai);
      end
      OP_LESS: begin
        cmp = (in_data.a_real < in_data.b_real) ||
              ((in_data.a_real == in_data.b_real) && (in_data.a_imag < in_data.b_imag));
      end
      OP_EQUAL: begin
        cmp = (in_data.a_real == in_data.b_real) && (in_data.a_imag == in_data.b_imag);
      end
      default: begin
        cmp = 1'b0;
      end
    endcase
    p1_dir_nxt.res_real     = c_re.word;
    p1_dir_nxt.res_imag     = c_im.word;
    p1_dir_nxt.compare_true = cmp;
    p1_dir_nxt.div_by_zero  = 1'b0;
    p1_dir_nxt.saturated    = c_re.sat | c_im.sat;
  end

  always_comb begin
    p2_den_nxt = p1_sq_r[0] + p1_sq_r[1];
    priority if (p1_op_r == OP_MUL) begin
      p2_s_nxt[0] = SW'(p1_prod_r[0]) - SW'(p1_prod_r[1]);
      p2_s_nxt[1] = SW'(p1_prod_r[2]) + SW'(p1_prod_r[3]);
    end else if (p1_op_r == OP_RECIP) begin
      p2_s_nxt[0] = SW'(p1_are_r);
      p2_s_nxt[1] = -SW'(p1_aim_r);
    end else begin
      p2_s_nxt[0] = SW'(p1_prod_r[0]) + SW'(p1_prod_r[1]);
      p2_s_nxt[1] = SW'(p1_prod_r[2]) - SW'(p1_prod_r[3]);
    end
  end

  always_comb begin
    logic [SW-1:0] mag [2];
    logic [CW-1:0] nn [2];
    logic [CW-1:0] lim;
    clamp_t        c0, c1;
    lim      = CW'(p2_den_r) << WORD_BITS;
    head_nxt = '0;
    for (int k = 0; k < 2; k++) begin
      head_nxt.tag.neg[k] = p2_s_r[k][SW-1];
      mag[k] = p2_s_r[k][SW-1] ? SW'(-p2_s_r[k]) : SW'(p2_s_r[k]);
      nn[k]  = (p2_op_r == OP_RECIP) ? (CW'(mag[k]) << (2 * FRAC_BITS))
                                     : (CW'(mag[k]) << FRAC_BITS);
      head_nxt.tag.ovf[k]   = nn[k] >= lim;
      head_nxt.lane[k].rem  = RW'(nn[k] >> WORD_BITS);
      head_nxt.lane[k].src  = {nn[k][WORD_BITS-1:0], {WORD_BITS{1'b0}}};
      head_nxt.lane[k].q    = '0;
    end
    c0 = clamp_mag(p2_s_r[0][SW-1], MW'(mag[0] >> FRAC_BITS));
    c1 = clamp_mag(p2_s_r[1][SW-1], MW'(mag[1] >> FRAC_BITS));
    head_nxt.valid      = p2_valid_r;
    head_nxt.tag.op     = p2_op_r;
    head_nxt.tag.direct = p2_dir_r;
    head_nxt.den        = p2_den_r;
    head_nxt.sqrt_mode  = 1'b0;
    unique case (p2_op_r)
      OP_MUL: begin
        head_nxt.tag.direct.res_real  = c0.word;
        head_nxt.tag.direct.res_imag  = c1.word;
        head_nxt.tag.direct.saturated = c0.sat | c1.sat;
      end
      OP_MAG: begin
        // root of the squared magnitude, two radicand bits per cell
        head_nxt.sqrt_mode   = 1'b1;
        head_nxt.lane[0].rem = '0;
        head_nxt.lane[0].src = p2_den_r;
        head_nxt.tag.neg     = '0;
        head_nxt.tag.ovf     = '0;
      end
      OP_DIV, OP_RECIP: begin
        if (p2_den_r == '0) begin
          head_nxt.tag.direct.div_by_zero = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r   <= 1'b0;
      p2_valid_r   <= 1'b0;
      head_valid_r <= 1'b0;
    end else if (en) begin
      p1_valid_r   <= in_take;
      p2_valid_r   <= p1_valid_r;
      head_valid_r <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_op_r   <= in_data.action;
      p1_are_r  <= in_data.a_real;
      p1_aim_r  <= in_data.a_imag;
      p1_dir_r  <= p1_dir_nxt;
      p1_prod_r <= p1_prod_nxt;
      p1_sq_r   <= p1_sq_nxt;
      p2_op_r   <= p1_op_r;
      p2_dir_r  <= p1_dir_r;
      p2_s_r    <= p2_s_nxt;
      p2_den_r  <= p2_den_nxt;
      head_r    <= head_nxt;
    end
  end

  always_comb begin
    head       = head_r;
    head.valid = head_valid_r;
  end

endmodule
`default_nettype wire

// ===== rtl/cau_cell.sv =====
`default_nettype none
module cau_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  cau_pkg::stage_t d_in,
  output cau_pkg::stage_t d_out
);
  import cau_pkg::*;

  logic   valid_r;
  stage_t stage_r, stage_nxt;

  // one restoring step per lane: shift in, trial subtract, keep or drop
  always_comb begin
    logic [RW+1:0] ext   [2];
    logic [RW+1:0] trial [2];
    logic [RW+1:0] diff  [2];
    logic          ge    [2];
    stage_nxt = d_in;
    for (int k = 0; k < 2; k++) begin
      ext[k]   = d_in.sqrt_mode ? {d_in.lane[k].rem, d_in.lane[k].src[RW-1 -: 2]}
                                : {1'b0, d_in.lane[k].rem, d_in.lane[k].src[RW-1]};
      trial[k] = d_in.sqrt_mode ? (RW+2)'({d_in.lane[k].q, 2'b01}) : (RW+2)'(d_in.den);
      ge[k]    = ext[k] >= trial[k];
      diff[k]  = ext[k] - trial[k];
      stage_nxt.lane[k].rem = ge[k] ? diff[k][RW-1:0] : ext[k][RW-1:0];
      stage_nxt.lane[k].q   = {d_in.lane[k].q[WORD_BITS-2:0], ge[k]};
      stage_nxt.lane[k].src = d_in.sqrt_mode ? {d_in.lane[k].src[RW-3:0], 2'b00}
                                             : {d_in.lane[k].src[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= d_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  always_comb begin
    d_out       = stage_r;
    d_out.valid = valid_r;
  end

endmodule
`default_nettype wire

// ===== rtl/cau_post.sv =====
`default_nettype none
module cau_post (
  input  cau_pkg::stage_t tail,
  output cau_pkg::out_t   res
);
  import cau_pkg::*;

  always_comb begin
    logic [MW-1:0] mg [2];
    clamp_t        c0, c1, cm;
    for (int k = 0; k < 2; k++) begin
      mg[k] = tail.tag.ovf[k] ? '1 : MW'(tail.lane[k].q);
    end
    c0  = clamp_mag(tail.tag.neg[0], mg[0]);
    c1  = clamp_mag(tail.tag.neg[1], mg[1]);
    cm  = clamp_mag(1'b0, MW'(tail.lane[0].q));
    res = tail.tag.direct;
    unique case (tail.tag.op)
      OP_DIV, OP_RECIP: begin
        if (!tail.tag.direct.div_by_zero) begin
          res.res_real  = c0.word;
          res.res_imag  = c1.word;
          res.saturated = c0.sat | c1.sat;
        end
      end
      OP_MAG: begin
        res.res_real  = cm.word;
        res.res_imag  = '0;
        res.saturated = cm.sat;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/complex_arithmetic_unit_top.sv =====
// Complex arithmetic unit on signed Q16.16 operand pairs: add, subtract, multiply, divide,
// negate, conjugate, magnitude, reciprocal, less-than and equality, one result beat per
// input beat, every result part clamped to the word range with the saturated flag raised.
// Throughput is one beat per cycle while in_stall is low. The pipe holds three setup
// stages (products, sums, lane setup), a chain of WORD_BITS identical shift/compare/subtract
// cells that each settle one quotient or root bit, and the output register. Divide and
// reciprocal run two lanes through the chain in parallel, one per result part; magnitude
// runs an integer square root in the real lane. When a result is held at the output and
// the skid stage fills, in_stall rises for as long as the skid stage stays full. Divide or
// reciprocal by zero returns zero with div_by_zero set.
`default_nettype none
`include "complex_arithmetic_unit_top_macros.svh"
module complex_arithmetic_unit_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cau_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cau_pkg::out_t out_data
);
  import cau_pkg::*;

  logic   en;
  logic   in_take, out_take;
  stage_t chain [NCELL+1];
  out_t   post_res;

  logic   out_valid_r, out_valid_nxt;
  logic   skid_valid_r, skid_valid_nxt;
  out_t   out_data_r, out_data_nxt;
  out_t   skid_data_r, skid_data_nxt;

  // Advance the whole pipe unless the skid stage holds a beat.
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign in_take  = in_valid && en;
  assign out_take = out_valid_r && !out_stall;

  cau_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_take (in_take),
    .in_data (in_data),
    .head    (chain[0])
  );

  // One cell per result bit; each hands its lanes to the next every cycle while en is high.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cau_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (chain[i]),
      .d_out (chain[i+1])
    );
  end

  // Apply sign and clamp to the chain's quotient or root.
  cau_post u_post (
    .tail (chain[NCELL]),
    .res  (post_res)
  );

  // Output register plus skid stage.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    priority if (skid_valid_r) begin
      // pipe is frozen; drain the skid beat once the output moves
      if (out_take) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (chain[NCELL].valid) begin
      if (!out_valid_r || out_take) begin
        out_data_nxt  = post_res;
        out_valid_nxt = 1'b1;
      end else begin
        // output held: park the beat in the skid stage
        skid_data_nxt  = post_res;
        skid_valid_nxt = 1'b1;
      end
    end else begin
      // nothing arriving: drop the output beat once taken
      if (out_take) begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CAU_ASSERT_IMP(a_skid_needs_out, skid_valid_r, out_valid_r, "skid beat without output beat")
  `CAU_ASSERT_NXT(a_skid_fill, !skid_valid_r && chain[NCELL].valid && out_valid_r && out_stall, skid_valid_r, "held output did not park the next beat")
  `CAU_ASSERT_IMP(a_dz_clean, out_valid_r && out_data_r.div_by_zero, out_data_r.res_real == '0 && out_data_r.res_imag == '0 && !out_data_r.saturated && !out_data_r.compare_true, "zero divisor with nonzero result")

endmodule
`default_nettype wire
